// ===== rtl/fprq_pkg.sv =====
// Shared types, action codes and default sizes for the FIFO page replacement queue.
`timescale 1ns / 1ps
`default_nettype none

package fprq_pkg;

	localparam int DEPTH_DEF     = 16;
	localparam int PAGE_BITS_DEF = 16;

	localparam logic [2:0] ACT_INSERT = 3'd0;
	localparam logic [2:0] ACT_POP    = 3'd1;
	localparam logic [2:0] ACT_REMOVE = 3'd2;
	localparam logic [2:0] ACT_CHECK  = 3'd3;
	localparam logic [2:0] ACT_CLEAR  = 3'd4;

	typedef struct packed {
		logic [2:0]  action;
		logic [15:0] page_id;
	} req_t;

	typedef struct packed {
		logic [15:0] oldest_page;
		logic        oldest_valid;
		logic        found;
		logic        accepted;
		logic [4:0]  entry_count;
	} rsp_t;

endpackage

`default_nettype wire

// ===== rtl/fifo_page_replacement_queue_core.sv =====
// Top level of the FIFO page replacement queue: control sequencer around the slot memory.
`timescale 1ns / 1ps
`default_nettype none

// The queue holds up to DEPTH resident page numbers in a circular buffer in one
// synchronous memory, oldest at the head. Each request word carries one action
// (insert, remove oldest, remove every copy of a page, check a page, clear) and
// yields exactly one response word with the oldest page after the action, its
// valid flag, a found flag, an accepted flag and the entry count. Requests are
// taken one at a time; req_stall stays high while one is in progress. With the
// response register free, insert, remove oldest, clear and unused codes pass
// from acceptance through the head read and result states to the response
// register; remove page and check first walk every held entry through the
// single read port of the slot memory, one entry a cycle, compacting survivors
// in place for remove page, before taking the same path. The response register frees
// the request side: a new request is taken while the previous response still
// waits. A full queue refuses an insert and an empty one refuses a remove
// oldest (accepted low); with the queue empty oldest_page reads zero.
// Page numbers are taken from the low PAGE_BITS bits of page_id.
module fifo_page_replacement_queue_core
	import fprq_pkg::*;
#(
	parameter int DEPTH     = DEPTH_DEF,
	parameter int PAGE_BITS = PAGE_BITS_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	output logic      req_stall,
	input  wire req_t req,
	output logic      rsp_valid,
	input  wire logic rsp_stall,
	output rsp_t      rsp
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_WALK = 4'b0010,
		ST_HEAD = 4'b0100,
		ST_HRES = 4'b1000
	} state_t;

	state_t state_q;

	logic [PTR_W-1:0]     head_q, tail_q, rd_ptr_q, wr_ptr_q;
	logic [CNT_W-1:0]     cnt_q, iss_q, kept_q;
	logic [2:0]           act_q;
	logic [PAGE_BITS-1:0] page_q;
	logic                 found_q, acc_q;
	logic                 rv_s1;
	logic                 out_vq;
	rsp_t                 out_q;

	logic                 req_acc, issue, match, out_free;
	logic [PAGE_BITS-1:0] req_page;
	logic [PAGE_BITS+15:0] req_ext, head_ext;
	logic [CNT_W+4:0]     cnt_ext;

	logic                 wen, ren;
	logic [PTR_W-1:0]     waddr, raddr;
	logic [PAGE_BITS-1:0] wdata, rdata;

	function automatic logic [PTR_W-1:0] inc_ptr(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	// Mask the page number to PAGE_BITS, zero-extending when that is wider.
	assign req_ext  = {PAGE_BITS'(0), req.page_id};
	assign req_page = req_ext[PAGE_BITS-1:0];
	assign head_ext = {16'd0, rdata};
	assign cnt_ext  = {5'd0, cnt_q};

	assign req_stall = (state_q != ST_IDLE);
	assign req_acc   = req_valid && !req_stall;
	assign issue     = (state_q == ST_WALK) && (iss_q < cnt_q);
	assign match     = (rdata == page_q);
	assign out_free  = !out_vq || !rsp_stall;

	assign rsp_valid = out_vq;
	assign rsp       = out_q;

	fprq_slot_ram #(
		.DEPTH     (DEPTH),
		.PAGE_BITS (PAGE_BITS)
	) u_slots (
		.clk     (clk),
		.wr_en   (wen),
		.wr_addr (waddr),
		.wr_data (wdata),
		.rd_en   (ren),
		.rd_addr (raddr),
		.rd_data (rdata)
	);

	// Memory port steering. A compacting write always lands on a slot already
	// read, so the walk needs no forwarding.
	always_comb begin
		wen   = 1'b0;
		waddr = tail_q;
		wdata = req_page;
		ren   = 1'b0;
		raddr = head_q;
		case (state_q)
			ST_IDLE: begin
				if (req_acc && req.action == ACT_INSERT && cnt_q < CNT_W'(DEPTH)) begin
					wen = 1'b1;
				end
			end
			ST_WALK: begin
				ren   = issue;
				raddr = rd_ptr_q;
				if (rv_s1 && !match && act_q == ACT_REMOVE) begin
					wen   = 1'b1;
					waddr = wr_ptr_q;
					wdata = rdata;
				end
			end
			ST_HEAD: begin
				ren = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// Sequencer and queue bookkeeping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			head_q  <= '0;
			tail_q  <= '0;
			cnt_q   <= '0;
			iss_q   <= '0;
			kept_q  <= '0;
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			act_q   <= '0;
			page_q  <= '0;
			found_q <= 1'b0;
			acc_q   <= 1'b0;
			rv_s1   <= 1'b0;
			out_vq  <= 1'b0;
			out_q   <= '0;
		end else begin
			// drop the response word once taken, unless a new one replaces it
			if (out_vq && !rsp_stall && state_q != ST_HRES) begin
				out_vq <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req_acc) begin
						act_q    <= req.action;
						page_q   <= req_page;
						found_q  <= 1'b0;
						rd_ptr_q <= head_q;
						wr_ptr_q <= head_q;
						iss_q    <= '0;
						kept_q   <= '0;
						rv_s1    <= 1'b0;
						case (req.action)
							ACT_INSERT: begin
								if (cnt_q < CNT_W'(DEPTH)) begin
									tail_q <= inc_ptr(tail_q);
									cnt_q  <= cnt_q + 1'b1;
									acc_q  <= 1'b1;
								end else begin
									acc_q <= 1'b0;
								end
								state_q <= ST_HEAD;
							end
							ACT_POP: begin
								if (cnt_q != '0) begin
									head_q <= inc_ptr(head_q);
									cnt_q  <= cnt_q - 1'b1;
									acc_q  <= 1'b1;
								end else begin
									acc_q <= 1'b0;
								end
								state_q <= ST_HEAD;
							end
							ACT_REMOVE, ACT_CHECK: begin
								acc_q   <= 1'b1;
								state_q <= ST_WALK;
							end
							ACT_CLEAR: begin
								cnt_q   <= '0;
								head_q  <= '0;
								tail_q  <= '0;
								acc_q   <= 1'b1;
								state_q <= ST_HEAD;
							end
							default: begin
								acc_q   <= 1'b0;
								state_q <= ST_HEAD;
							end
						endcase
					end
				end
				ST_WALK: begin
					// advance the read side one entry a cycle
					rv_s1 <= issue;
					if (issue) begin
						rd_ptr_q <= inc_ptr(rd_ptr_q);
						iss_q    <= iss_q + 1'b1;
					end
					// compare the entry read last cycle; keep survivors in order
					if (rv_s1) begin
						if (match) begin
							found_q <= 1'b1;
						end else begin
							wr_ptr_q <= inc_ptr(wr_ptr_q);
							kept_q   <= kept_q + 1'b1;
						end
					end
					if (!issue && !rv_s1) begin
						if (act_q == ACT_REMOVE) begin
							cnt_q  <= kept_q;
							tail_q <= wr_ptr_q;
						end
						state_q <= ST_HEAD;
					end
				end
				ST_HEAD: begin
					state_q <= ST_HRES;
				end
				ST_HRES: begin
					// hold here until the response register is free
					if (out_free) begin
						out_q.oldest_page  <= (cnt_q != '0) ? head_ext[15:0] : 16'd0;
						out_q.oldest_valid <= (cnt_q != '0);
						out_q.found        <= found_q;
						out_q.accepted     <= acc_q;
						out_q.entry_count  <= cnt_ext[4:0];
						out_vq             <= 1'b1;
						state_q            <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(DEPTH))
		else $error("held count exceeds queue depth");

	a_kept_le_issued: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_WALK |-> kept_q <= iss_q)
		else $error("walk kept more entries than it read");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		req_acc && req.action == ACT_CLEAR |=> cnt_q == '0)
		else $error("clear did not empty the queue");

	a_rsp_from_hres: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(state_q == ST_HRES))
		else $error("response word loaded outside the result state");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_acc |=> req_stall)
		else $error("request side free right after accepting a word");

endmodule

`default_nettype wire

// ===== rtl/fprq_slot_ram.sv =====
// Page slot memory: one write port, one read port, registered read data.
`timescale 1ns / 1ps
`default_nettype none

module fprq_slot_ram
	import fprq_pkg::*;
#(
	parameter int DEPTH     = DEPTH_DEF,
	parameter int PAGE_BITS = PAGE_BITS_DEF,
	localparam int PTR_W    = $clog2(DEPTH)
) (
	input  wire logic                 clk,
	input  wire logic                 wr_en,
	input  wire logic [PTR_W-1:0]     wr_addr,
	input  wire logic [PAGE_BITS-1:0] wr_data,
	input  wire logic                 rd_en,
	input  wire logic [PTR_W-1:0]     rd_addr,
	output logic      [PAGE_BITS-1:0] rd_data
);

	logic [PAGE_BITS-1:0] slots [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			slots[wr_addr] <= wr_data;
		end
	end

	// hold read data until the next read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= slots[rd_addr];
		end
	end

endmodule

`default_nettype wire
